// File: hw/rtl/nrcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcp_pkg
// Shared types and constants for the normalized 64-bit reciprocal core.
// ----------------------------------------------------------------------------
package nrcp_pkg;

	// Width of the divisor field on the input stream.
	localparam int unsigned DIVISOR_W = 32;

	// Default number of divisor bits actually used.
	localparam int unsigned DIVISOR_BITS_DEFAULT = 32;

	// Number of quotient bits, one division cell per bit.
	localparam int unsigned QUO_BITS = 64;

	// Width of the status field.
	localparam int unsigned STATUS_W = 2;

	// Packed output beat widths: reciprocal, then status, padded to bytes.
	localparam int unsigned OUT_DATA_W = QUO_BITS + STATUS_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_VALID = 2'd0,
		STATUS_ZERO  = 2'd1,
		STATUS_POW2  = 2'd2
	} status_t;

endpackage

// File: hw/rtl/normalized_reciprocal_64_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_reciprocal_64_core
// Streams 32-bit divisors in and returns floor(2^(63+s)/d) mod 2^64 with a
// status code, where s is the bit length of the divisor.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  tdata fields (low bit first)            Beat
//   s_*      in   divisor[31:0]                           one divisor
//   m_*      out  reciprocal[63:0], status[65:64], pad    one result
//
// Flow: one beat is accepted per clock while the chain is not stalled. A
// divisor passes 65 register stages (one normalize stage plus 64 division
// cells, one quotient bit per cell) before its result shows on m_tvalid.
// Throughput is set by the cell chain, which takes a new item every cycle
// while m_tready does not stall it.
// Reset: arst_n clears every stage's valid flag; no results are pending after.
// Stalls: each stage holds its beat while the next stage is full and stalled,
// so empty stages keep filling while a result waits on m_tready.
//
// Method: the divisor is shifted left until its top bit is set. With that
// normalized divisor dn, the wanted value equals floor(2^(63+W)/dn) for a
// divisor width W, which a plain restoring division yields bit by bit.
// Zero and power-of-two divisors are flagged and return a reciprocal of 0.
// ----------------------------------------------------------------------------
module normalized_reciprocal_64_core #(
	parameter int unsigned DIVISOR_BITS = nrcp_pkg::DIVISOR_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [nrcp_pkg::DIVISOR_W-1:0]   s_tdata,  // [31:0] divisor
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nrcp_pkg::OUT_TDATA_W-1:0] m_tdata   // [63:0] reciprocal,
	                                                   // [65:64] status, rest 0
);

	localparam int unsigned NQ = nrcp_pkg::QUO_BITS;

	// Link signals of the chain; index 0 is the normalize stage's output,
	// index NQ the last cell's output.
	logic                    valid_c  [0:NQ];
	logic                    ready_c  [0:NQ];
	logic [DIVISOR_BITS-1:0] dvsr_c   [0:NQ];
	logic [DIVISOR_BITS-1:0] rem_c    [0:NQ];
	logic [NQ-1:0]           quo_c    [0:NQ];
	nrcp_pkg::status_t       status_c [0:NQ];

	logic [NQ-1:0]           reciprocal;

	nrcp_norm #(
		.DIVISOR_BITS(DIVISOR_BITS)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_dvsr   (s_tdata[DIVISOR_BITS-1:0]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_dvsr  (dvsr_c[0]),
		.out_rem   (rem_c[0]),
		.out_status(status_c[0])
	);

	// Quotient bits above the 64 we keep are zero for every divisor that is
	// not a power of two, so the accumulator starts empty.
	assign quo_c[0] = '0;

	for (genvar i = 0; i < NQ; i++) begin : g_cell
		nrcp_cell #(
			.DIVISOR_BITS(DIVISOR_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_dvsr   (dvsr_c[i]),
			.in_rem    (rem_c[i]),
			.in_quo    (quo_c[i]),
			.in_status (status_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_dvsr  (dvsr_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_quo   (quo_c[i+1]),
			.out_status(status_c[i+1])
		);
	end

	assign ready_c[NQ] = m_tready;
	assign m_tvalid    = valid_c[NQ];

	// Flagged divisors return zero; for a power of two the true quotient is
	// 2^64, which wraps to zero anyway.
	assign reciprocal = (status_c[NQ] == nrcp_pkg::STATUS_VALID) ? quo_c[NQ] : '0;

	assign m_tdata = {{(nrcp_pkg::OUT_TDATA_W - nrcp_pkg::OUT_DATA_W){1'b0}},
	                  status_c[NQ], reciprocal};

	// A valid reciprocal always lies strictly between 2^63 and 2^64.
	a_valid_top_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_c[NQ] == nrcp_pkg::STATUS_VALID)) |-> quo_c[NQ][NQ-1])
		else $error("valid reciprocal below 2^63");

	// A nonzero divisor leaves the chain normalized, with its top bit set.
	a_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_c[NQ] != nrcp_pkg::STATUS_ZERO)) |->
		dvsr_c[NQ][DIVISOR_BITS-1])
		else $error("divisor not normalized at chain end");

	// The final remainder of a valid division stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_c[NQ] == nrcp_pkg::STATUS_VALID)) |->
		(rem_c[NQ] < dvsr_c[NQ]))
		else $error("remainder not below divisor");

	// A free output lets every stage advance, so the input is open too.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output is ready");

endmodule

// File: hw/rtl/nrcp_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcp_norm
// Front stage: shifts the divisor left until its top bit is set, classifies
// it and seeds the partial remainder for the division cells.
// ----------------------------------------------------------------------------
module nrcp_norm #(
	parameter int unsigned DIVISOR_BITS = nrcp_pkg::DIVISOR_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [DIVISOR_BITS-1:0] in_dvsr,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DIVISOR_BITS-1:0] out_dvsr,
	output logic [DIVISOR_BITS-1:0] out_rem,
	output nrcp_pkg::status_t       out_status
);

	localparam int unsigned SH_STEPS = $clog2(DIVISOR_BITS);
	localparam logic [DIVISOR_BITS-1:0] TOP_BIT = {1'b1, {(DIVISOR_BITS-1){1'b0}}};

	logic [DIVISOR_BITS-1:0] norm;
	nrcp_pkg::status_t       status;
	logic                    valid_q;
	logic [DIVISOR_BITS-1:0] dvsr_q;
	nrcp_pkg::status_t       status_q;

	// Binary leading-zero shift: each step removes a power-of-two run of zeros.
	always_comb begin
		norm = in_dvsr;
		for (int k = SH_STEPS - 1; k >= 0; k--) begin
			if ((norm >> (DIVISOR_BITS - (1 << k))) == '0) begin
				norm = norm << (1 << k);
			end
		end
	end

	always_comb begin
		if (norm == '0) begin
			status = nrcp_pkg::STATUS_ZERO;
		end else if (norm == TOP_BIT) begin
			status = nrcp_pkg::STATUS_POW2;
		end else begin
			status = nrcp_pkg::STATUS_VALID;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dvsr_q   <= norm;
			status_q <= status;
		end
	end

	assign out_valid  = valid_q;
	assign out_dvsr   = dvsr_q;
	// The dividend 2^(63+W) starts with its top W bits equal to 2^(W-1).
	assign out_rem    = TOP_BIT;
	assign out_status = status_q;

endmodule

// File: hw/rtl/nrcp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcp_cell
// One restoring-division cell: brings down a zero bit of the dividend,
// produces one quotient bit and hands the item to the next cell.
// ----------------------------------------------------------------------------
module nrcp_cell #(
	parameter int unsigned DIVISOR_BITS = nrcp_pkg::DIVISOR_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [DIVISOR_BITS-1:0]       in_dvsr,
	input  logic [DIVISOR_BITS-1:0]       in_rem,
	input  logic [nrcp_pkg::QUO_BITS-1:0] in_quo,
	input  nrcp_pkg::status_t             in_status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DIVISOR_BITS-1:0]       out_dvsr,
	output logic [DIVISOR_BITS-1:0]       out_rem,
	output logic [nrcp_pkg::QUO_BITS-1:0] out_quo,
	output nrcp_pkg::status_t             out_status
);

	logic [DIVISOR_BITS:0]         trial;
	logic [DIVISOR_BITS:0]         diff;
	logic                          q_bit;
	logic [DIVISOR_BITS-1:0]       rem_next;
	logic                          valid_q;
	logic [DIVISOR_BITS-1:0]       dvsr_q;
	logic [DIVISOR_BITS-1:0]       rem_q;
	logic [nrcp_pkg::QUO_BITS-1:0] quo_q;
	nrcp_pkg::status_t             status_q;

	// For a nonzero divisor the partial remainder never exceeds the divisor, so
	// the difference and the kept value both fit in DIVISOR_BITS bits.
	always_comb begin
		trial    = {in_rem, 1'b0};
		diff     = trial - {1'b0, in_dvsr};
		q_bit    = (trial >= {1'b0, in_dvsr});
		rem_next = q_bit ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dvsr_q   <= in_dvsr;
			rem_q    <= rem_next;
			quo_q    <= {in_quo[nrcp_pkg::QUO_BITS-2:0], q_bit};
			status_q <= in_status;
		end
	end

	assign out_valid  = valid_q;
	assign out_dvsr   = dvsr_q;
	assign out_rem    = rem_q;
	assign out_quo    = quo_q;
	assign out_status = status_q;

endmodule
